[sv/ddo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

   // encoder count width and rotation steps of the sine/cosine unit
   localparam int COUNT_WIDTH  = 16;
   localparam int CORDIC_STEPS = 24;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((2 * COUNT_WIDTH + 32 + 7) / 8) * 8;
   localparam int RSP_DATA_W = 96;

   // configuration register indexes
   localparam logic [1:0] REG_LEFT_PER_COUNT  = 2'd0;
   localparam logic [1:0] REG_RIGHT_PER_COUNT = 2'd1;
   localparam logic [1:0] REG_TRACK_WIDTH     = 2'd2;
   localparam logic [1:0] REG_INIT_HEADING    = 2'd3;

   // register defaults
   localparam logic [23:0]        LEFT_PER_COUNT_RST  = 24'd207183;
   localparam logic [23:0]        RIGHT_PER_COUNT_RST = 24'd207183;
   localparam logic [23:0]        TRACK_WIDTH_RST     = 24'd550502;
   localparam logic signed [31:0] INIT_HEADING_RST    = -32'sd13176795;

   // operation selector
   localparam logic OP_TICK        = 1'b0;
   localparam logic OP_SET_HEADING = 1'b1;

   // angles in 2^-24 rad, cordic gain in Q2.30
   localparam logic signed [35:0] TWO_PI_Q24  = 36'sd105414357;
   localparam logic signed [35:0] PI_Q24      = 36'sd52707179;
   localparam logic signed [35:0] HALF_PI_Q24 = 36'sd26353589;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   // arc length limit, 2^-24 inch
   localparam logic signed [67:0] ARC_LIMIT = 68'sd35184372088832;

   // atan(2^-k) in 2^-24 rad
   function automatic logic [23:0] atan_q24(input logic [4:0] k);
      logic [23:0] v;
      case (k)
         5'd0:  v = 24'd13176795;
         5'd1:  v = 24'd7778716;
         5'd2:  v = 24'd4110060;
         5'd3:  v = 24'd2086331;
         5'd4:  v = 24'd1047214;
         5'd5:  v = 24'd524117;
         5'd6:  v = 24'd262123;
         5'd7:  v = 24'd131069;
         5'd8:  v = 24'd65536;
         5'd9:  v = 24'd32768;
         5'd10: v = 24'd16384;
         5'd11: v = 24'd8192;
         5'd12: v = 24'd4096;
         5'd13: v = 24'd2048;
         5'd14: v = 24'd1024;
         5'd15: v = 24'd512;
         5'd16: v = 24'd256;
         5'd17: v = 24'd128;
         5'd18: v = 24'd64;
         5'd19: v = 24'd32;
         5'd20: v = 24'd16;
         5'd21: v = 24'd8;
         5'd22: v = 24'd4;
         5'd23: v = 24'd2;
         5'd24: v = 24'd1;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[sv/diff_drive_odometry.sv]
`timescale 1ns / 1ps
`default_nettype none

// Dead-reckoning odometry for a two-wheel robot. Each req_ transaction either
// loads the heading (tuser = 1, through the heading register into the result
// register) or applies one encoder tick: both arcs go through one shared 34x18
// multiplier, the heading change and the turn radius through one shared
// restoring divider (skipped when the quotient saturates), and sine/cosine
// through one shared CORDIC unit (range reduction, a fold and then the
// rotation steps per angle). A straight tick skips the turn radius and the
// second angle. One item is worked at a time; the next is taken once the
// result sits in the rsp_ output register. Position is Q15.16 inch, heading
// Q7.24 rad, both saturating. Writes to the initial heading register have no
// effect, as reset restores its default.
module diff_drive_odometry (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: left_delta, right_delta_raw, heading_value
   input  wire logic [ddo_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: operation
   input  wire logic                            req_tuser,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: pos_x, pos_y, heading
   output logic [ddo_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [31:0]                     csr_wdata
);

   localparam int CW = ddo_pkg::COUNT_WIDTH;
   localparam int LAST_STEP = ddo_pkg::CORDIC_STEPS - 1;

   typedef enum logic [3:0] {
      S_IDLE, S_ARC_L, S_ARC_R, S_DA_INIT, S_DIV_RUN, S_DA_END, S_RAD_INIT,
      S_RAD_END, S_RED, S_FOLD, S_ROT, S_MUL_X, S_MUL_Y, S_UPDATE, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        half_ff, half_in;

   logic [23:0] left_ff, left_in, right_ff, right_in, tw_ff, tw_in;

   logic signed [CW:0]  cl_ff, cl_in, cr_ff, cr_in;
   logic signed [46:0]  al_ff, al_in, ar_ff, ar_in;
   logic                outer_ff, outer_in;
   logic signed [31:0]  da_ff, da_in;
   logic [30:0]         bigr_ff, bigr_in;
   logic signed [33:0]  a16_ff, a16_in;

   logic [62:0] rem_ff, rem_in;
   logic [61:0] den_ff, den_in;
   logic [30:0] quo_ff, quo_in;
   logic        dneg_ff, dneg_in, dsat_ff, dsat_in, dsel_ff, dsel_in;

   logic [32:0]        tm_ff, tm_in;
   logic               tneg_ff, tneg_in, tsel_ff, tsel_in, flip_ff, flip_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] cz_ff, cz_in;
   logic signed [33:0] c0_ff, c0_in, s0_ff, s0_in, c1_ff, c1_in, s1_ff, s1_in;

   logic signed [67:0] prod_ff, prod_in;
   logic signed [37:0] dx_ff, dx_in;

   logic signed [31:0] x_ff, x_in, y_ff, y_in, h_ff, h_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ddo_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared datapath signals
   logic signed [33:0] mul_a, mul_b;
   logic signed [17:0] mul_bp;
   logic signed [51:0] mul_p;
   logic signed [67:0] mul_ext;
   logic signed [67:0] rnd_sum;
   logic signed [37:0] rnd;
   logic signed [46:0] arc_clamped;
   logic signed [47:0] adiff;
   logic [46:0]        adiff_mag, al_mag, ar_mag, inner_mag;
   logic [62:0]        div_num;
   logic [31:0]        div_den;
   logic [31:0]        tw_eff;
   logic [31:0]        da_mag;
   logic signed [32:0] tload_ang;
   logic               tload;
   logic signed [33:0] tp_sh;
   logic signed [34:0] fold_r;
   logic [4:0]         rot_k;
   logic signed [33:0] rot_x, rot_y, rot_xs, rot_ys;
   logic signed [31:0] rot_z, rot_at;
   logic signed [37:0] a16_full;
   logic signed [32:0] h_sum;
   logic [31:0]        rad_sum;
   logic signed [38:0] x_sum, y_sum;
   logic signed [37:0] dy_val;
   logic               straight;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign straight   = (da_ff == 32'sd0);
   assign tw_eff     = (tw_ff == 24'd0) ? 32'd1 : {8'd0, tw_ff};

   // shared multiplier: operand b in two 17-bit halves, low half unsigned
   assign mul_bp  = half_ff ? {mul_b[33], mul_b[33:17]} : {1'b0, mul_b[16:0]};
   assign mul_p   = mul_a * mul_bp;
   assign mul_ext = {{16{mul_p[51]}}, mul_p};

   // arc clamp of the finished product
   always_comb begin
      if (prod_ff > ddo_pkg::ARC_LIMIT) arc_clamped = ddo_pkg::ARC_LIMIT[46:0];
      else if (prod_ff < -ddo_pkg::ARC_LIMIT) arc_clamped = 47'(-ddo_pkg::ARC_LIMIT);
      else arc_clamped = prod_ff[46:0];
   end

   // product rounded half up to 2^-16 inch
   assign rnd_sum = prod_ff + 68'sd536870912;
   assign rnd     = rnd_sum[67:30];

   // arc difference and magnitudes, right arc still in the product register
   assign adiff     = 48'(al_ff) - 48'(arc_clamped);
   assign adiff_mag = adiff[47] ? 47'(-adiff) : adiff[46:0];
   assign al_mag    = al_ff[46] ? 47'(-al_ff) : al_ff;
   assign ar_mag    = ar_ff[46] ? 47'(-ar_ff) : ar_ff;
   assign inner_mag = outer_ff ? ar_mag : al_mag;
   assign da_mag    = da_ff[31] ? 32'(-da_ff) : 32'(da_ff);
   assign rad_sum   = {1'b0, quo_ff} + {9'd0, tw_ff[23:1]};

   // straight arc in 2^-16 inch, limited to +-2^32
   assign a16_full = 38'((48'(al_ff) + 48'sd128) >>> 8);

   assign h_sum = 33'(h_ff) + 33'(da_ff);

   // cordic rotation step
   assign rot_k  = cnt_ff[4:0];
   assign rot_xs = cx_ff >>> rot_k;
   assign rot_ys = cy_ff >>> rot_k;
   assign rot_at = {8'd0, ddo_pkg::atan_q24(rot_k)};
   always_comb begin
      if (!cz_ff[31]) begin
         rot_x = cx_ff - rot_ys;
         rot_y = cy_ff + rot_xs;
         rot_z = cz_ff - rot_at;
      end else begin
         rot_x = cx_ff + rot_ys;
         rot_y = cy_ff - rot_xs;
         rot_z = cz_ff + rot_at;
      end
   end

   assign tp_sh  = 34'(ddo_pkg::TWO_PI_Q24) <<< cnt_ff[2:0];
   assign dy_val = (!straight && !outer_ff) ? -rnd : rnd;
   assign x_sum  = 39'(x_ff) + 39'(dx_ff);
   assign y_sum  = 39'(y_ff) + 39'(dy_val);

   // sequencer and datapath next state
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      half_in = half_ff;
      left_in = left_ff;
      right_in = right_ff;
      tw_in = tw_ff;
      cl_in = cl_ff;
      cr_in = cr_ff;
      al_in = al_ff;
      ar_in = ar_ff;
      outer_in = outer_ff;
      da_in = da_ff;
      bigr_in = bigr_ff;
      a16_in = a16_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      dneg_in = dneg_ff;
      dsat_in = dsat_ff;
      dsel_in = dsel_ff;
      tm_in = tm_ff;
      tneg_in = tneg_ff;
      tsel_in = tsel_ff;
      flip_in = flip_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      c0_in = c0_ff;
      s0_in = s0_ff;
      c1_in = c1_ff;
      s1_in = s1_ff;
      prod_in = prod_ff;
      dx_in = dx_ff;
      x_in = x_ff;
      y_in = y_ff;
      h_in = h_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      mul_a = '0;
      mul_b = '0;
      div_num = '0;
      div_den = '0;
      tload = 1'b0;
      tload_ang = '0;
      fold_r = '0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            ddo_pkg::REG_LEFT_PER_COUNT:  left_in = csr_wdata[23:0];
            ddo_pkg::REG_RIGHT_PER_COUNT: right_in = csr_wdata[23:0];
            ddo_pkg::REG_TRACK_WIDTH:     tw_in = csr_wdata[23:0];
            ddo_pkg::REG_INIT_HEADING:    ;
            default: ;
         endcase
      end

      // output register drains
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ddo_pkg::OP_SET_HEADING) begin
                  h_in = req_tdata[2*CW+31:2*CW];
                  state_in = S_DONE;
               end else begin
                  cl_in = {req_tdata[CW-1], req_tdata[CW-1:0]};
                  cr_in = -{req_tdata[2*CW-1], req_tdata[2*CW-1:CW]};
                  half_in = 1'b0;
                  state_in = S_ARC_L;
               end
            end
         end
         S_ARC_L: begin
            mul_a = 34'(cl_ff);
            mul_b = {10'd0, left_ff};
            prod_in = half_ff ? prod_ff + (mul_ext <<< 17) : mul_ext;
            half_in = ~half_ff;
            if (half_ff) state_in = S_ARC_R;
         end
         S_ARC_R: begin
            if (!half_ff) al_in = arc_clamped;
            mul_a = 34'(cr_ff);
            mul_b = {10'd0, right_ff};
            prod_in = half_ff ? prod_ff + (mul_ext <<< 17) : mul_ext;
            half_in = ~half_ff;
            if (half_ff) state_in = S_DA_INIT;
         end
         S_DA_INIT: begin
            ar_in = arc_clamped;
            outer_in = (al_mag > (arc_clamped[46] ? 47'(-arc_clamped) : arc_clamped));
            div_num = {adiff_mag[46:0], 16'd0};
            div_den = tw_eff;
            dneg_in = adiff[47];
            dsel_in = 1'b0;
            rem_in = div_num;
            den_in = {div_den, 30'd0};
            quo_in = '0;
            cnt_in = '0;
            dsat_in = (div_num >= {div_den, 31'd0});
            state_in = dsat_in ? S_DA_END : S_DIV_RUN;
         end
         S_DIV_RUN: begin
            if (rem_ff >= {1'b0, den_ff}) begin
               rem_in = rem_ff - {1'b0, den_ff};
               quo_in = {quo_ff[29:0], 1'b1};
            end else begin
               quo_in = {quo_ff[29:0], 1'b0};
            end
            den_in = den_ff >> 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd30) state_in = dsel_ff ? S_RAD_END : S_DA_END;
         end
         S_DA_END: begin
            if (dsat_ff) da_in = dneg_ff ? 32'sh80000000 : 32'sh7fffffff;
            else da_in = dneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
            if (da_in == 32'sd0) begin
               if (a16_full > 38'sd4294967296) a16_in = 34'sd4294967296;
               else if (a16_full < -38'sd4294967296) a16_in = -34'sd4294967296;
               else a16_in = a16_full[33:0];
               tload = 1'b1;
               tload_ang = 33'(h_ff);
               tsel_in = 1'b0;
            end else begin
               state_in = S_RAD_INIT;
            end
         end
         S_RAD_INIT: begin
            div_num = {inner_mag[46:0], 16'd0};
            div_den = da_mag;
            dsel_in = 1'b1;
            rem_in = div_num;
            den_in = {div_den, 30'd0};
            quo_in = '0;
            cnt_in = '0;
            dsat_in = (div_num >= {div_den, 31'd0});
            state_in = dsat_in ? S_RAD_END : S_DIV_RUN;
         end
         S_RAD_END: begin
            if (dsat_ff || rad_sum[31]) bigr_in = 31'h7fffffff;
            else bigr_in = rad_sum[30:0];
            tload = 1'b1;
            tload_ang = 33'(h_ff);
            tsel_in = 1'b0;
         end
         S_RED: begin
            if ($signed({1'b0, tm_ff}) >= tp_sh) tm_in = 33'($signed({1'b0, tm_ff}) - tp_sh);
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_FOLD;
         end
         S_FOLD: begin
            fold_r = tneg_ff ? -$signed({2'b0, tm_ff}) : $signed({2'b0, tm_ff});
            if (fold_r > 35'(ddo_pkg::PI_Q24)) fold_r = fold_r - 35'(ddo_pkg::TWO_PI_Q24);
            else if (fold_r < -35'(ddo_pkg::PI_Q24)) fold_r = fold_r + 35'(ddo_pkg::TWO_PI_Q24);
            flip_in = 1'b0;
            if (fold_r > 35'(ddo_pkg::HALF_PI_Q24)) begin
               fold_r = fold_r - 35'(ddo_pkg::PI_Q24);
               flip_in = 1'b1;
            end else if (fold_r < -35'(ddo_pkg::HALF_PI_Q24)) begin
               fold_r = fold_r + 35'(ddo_pkg::PI_Q24);
               flip_in = 1'b1;
            end
            cx_in = ddo_pkg::GAIN_Q30;
            cy_in = '0;
            cz_in = fold_r[31:0];
            cnt_in = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            cx_in = rot_x;
            cy_in = rot_y;
            cz_in = rot_z;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(LAST_STEP)) begin
               if (!tsel_ff) begin
                  c0_in = flip_ff ? -rot_x : rot_x;
                  s0_in = flip_ff ? -rot_y : rot_y;
               end else begin
                  c1_in = flip_ff ? -rot_x : rot_x;
                  s1_in = flip_ff ? -rot_y : rot_y;
               end
               if (!tsel_ff && !straight) begin
                  tload = 1'b1;
                  tload_ang = h_sum;
                  tsel_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  state_in = S_MUL_X;
               end
            end
         end
         S_MUL_X: begin
            mul_a = straight ? a16_ff : $signed({3'd0, bigr_ff});
            mul_b = straight ? s0_ff : c1_ff - c0_ff;
            prod_in = half_ff ? prod_ff + (mul_ext <<< 17) : mul_ext;
            half_in = ~half_ff;
            if (half_ff) state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            if (!half_ff) dx_in = (!straight && outer_ff) ? -rnd : rnd;
            mul_a = straight ? a16_ff : $signed({3'd0, bigr_ff});
            mul_b = straight ? c0_ff : s1_ff - s0_ff;
            prod_in = half_ff ? prod_ff + (mul_ext <<< 17) : mul_ext;
            half_in = ~half_ff;
            if (half_ff) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (x_sum > 39'sd2147483647) x_in = 32'sh7fffffff;
            else if (x_sum < -39'sd2147483648) x_in = 32'sh80000000;
            else x_in = x_sum[31:0];
            if (y_sum > 39'sd2147483647) y_in = 32'sh7fffffff;
            else if (y_sum < -39'sd2147483648) y_in = 32'sh80000000;
            else y_in = y_sum[31:0];
            if (!straight) begin
               if (h_sum > 33'sd2147483647) h_in = 32'sh7fffffff;
               else if (h_sum < -33'sd2147483648) h_in = 32'sh80000000;
               else h_in = h_sum[31:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {h_ff, y_ff, x_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // start of a sine/cosine evaluation: magnitude for range reduction
      if (tload) begin
         tneg_in = tload_ang[32];
         tm_in = tload_ang[32] ? 33'(-tload_ang) : tload_ang;
         cnt_in = 6'd5;
         state_in = S_RED;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         half_ff <= 1'b0;
         left_ff <= ddo_pkg::LEFT_PER_COUNT_RST;
         right_ff <= ddo_pkg::RIGHT_PER_COUNT_RST;
         tw_ff <= ddo_pkg::TRACK_WIDTH_RST;
         da_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         h_ff <= ddo_pkg::INIT_HEADING_RST;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         half_ff <= half_in;
         left_ff <= left_in;
         right_ff <= right_in;
         tw_ff <= tw_in;
         da_ff <= da_in;
         x_ff <= x_in;
         y_ff <= y_in;
         h_ff <= h_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cl_ff <= cl_in;
      cr_ff <= cr_in;
      al_ff <= al_in;
      ar_ff <= ar_in;
      outer_ff <= outer_in;
      bigr_ff <= bigr_in;
      a16_ff <= a16_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      dneg_ff <= dneg_in;
      dsat_ff <= dsat_in;
      dsel_ff <= dsel_in;
      tm_ff <= tm_in;
      tneg_ff <= tneg_in;
      tsel_ff <= tsel_in;
      flip_ff <= flip_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      c0_ff <= c0_in;
      s0_ff <= s0_in;
      c1_ff <= c1_in;
      s1_ff <= s1_in;
      prod_ff <= prod_in;
      dx_ff <= dx_in;
   end

endmodule

`default_nettype wire

[sv/ddo_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ddo_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic [ddo_pkg::REQ_DATA_W-1:0]  req_tdata,
   input wire logic                            req_tuser,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [ddo_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready
);

   localparam int HV_LO = 2 * ddo_pkg::COUNT_WIDTH;

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // busy after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while an item is in work");

   // a new result only comes from a transaction in work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a transaction in work");

   // set heading shows up on the result stream, via the heading register, when the output is free
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ddo_pkg::OP_SET_HEADING &&
      (!rsp_tvalid || rsp_tready)
      |-> ##2 (rsp_tvalid && rsp_tdata[95:64] == $past(req_tdata[HV_LO+31:HV_LO], 2)))
      else $error("set heading result wrong or late");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

`default_nettype wire
